// File: hw/rtl/dllm_pkg.sv
package dllm_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = $clog2(NODES);
    localparam int LINK_W = NODE_W + 1;

    // link value that stands for no node
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

    typedef enum logic [2:0] {
        OP_INS_FIRST  = 3'd0,
        OP_INS_LAST   = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_INS_BEFORE = 3'd3,
        OP_REM_FIRST  = 3'd4,
        OP_REM_LAST   = 3'd5,
        OP_REMOVE     = 3'd6,
        OP_SEARCH     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LISTED    = 3'd1,
        ST_NO_ANCHOR = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_UNLISTED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_FIN  = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// File: hw/rtl/dllm_ctrl.sv
module dllm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dllm_pkg::stat_t stat,
    output dllm_pkg::cmd_t  cmd
);

    dllm_pkg::state_t state_reg;
    dllm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dllm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.exec_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            dllm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = dllm_pkg::S_EXEC;
                end
            end
            dllm_pkg::S_EXEC:
            begin
                cmd.exec_step = 1'b1;
                state_next    = dllm_pkg::S_FIN;
            end
            dllm_pkg::S_FIN:
            begin
                // second link writes repeat harmlessly while the result waits
                cmd.finish = 1'b1;
                if (stat.out_free)
                begin
                    state_next = dllm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dllm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/dllm_datapath.sv
module dllm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dllm_pkg::cmd_t                cmd,
    output dllm_pkg::stat_t               stat,
    input  logic [2:0]                    op,
    input  logic [dllm_pkg::NODE_W-1:0]   node,
    input  logic [dllm_pkg::NODE_W-1:0]   anchor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dllm_pkg::LINK_W-1:0]   result_node,
    output logic                          found,
    output logic [2:0]                    status,
    output logic [dllm_pkg::LINK_W-1:0]   count
);

    localparam int NW = dllm_pkg::NODE_W;
    localparam int LW = dllm_pkg::LINK_W;

    // link tables
    logic [LW-1:0] next_mem [dllm_pkg::NODES];
    logic [LW-1:0] prev_mem [dllm_pkg::NODES];

    logic [LW-1:0] rd_next_reg;
    logic [LW-1:0] rd_prev_reg;
    logic [NW-1:0] rd_next_addr;
    logic [NW-1:0] rd_prev_addr;

    logic          nx_we;
    logic [NW-1:0] nx_wa;
    logic [LW-1:0] nx_wd;
    logic          pv_we;
    logic [NW-1:0] pv_wa;
    logic [LW-1:0] pv_wd;

    // captured item
    dllm_pkg::op_t op_reg;
    logic [NW-1:0] node_reg;
    logic [NW-1:0] anchor_reg;

    // list state
    logic [dllm_pkg::NODES-1:0] member_reg;
    logic [dllm_pkg::NODES-1:0] member_next;
    logic [LW-1:0] head_reg;
    logic [LW-1:0] head_next;
    logic [LW-1:0] tail_reg;
    logic [LW-1:0] tail_next;
    logic [LW-1:0] size_reg;
    logic [LW-1:0] size_next;

    // pending result and second link writes
    logic [LW-1:0]       res_reg;
    logic [LW-1:0]       res_next;
    logic                fnd_reg;
    logic                fnd_next;
    dllm_pkg::status_t   st_reg;
    dllm_pkg::status_t   st_next;
    logic                w2_nx_we_reg;
    logic                w2_nx_we_next;
    logic [NW-1:0]       w2_nx_wa_reg;
    logic [NW-1:0]       w2_nx_wa_next;
    logic [LW-1:0]       w2_nx_wd_reg;
    logic [LW-1:0]       w2_nx_wd_next;
    logic                w2_pv_we_reg;
    logic                w2_pv_we_next;
    logic [NW-1:0]       w2_pv_wa_reg;
    logic [NW-1:0]       w2_pv_wa_next;
    logic [LW-1:0]       w2_pv_wd_reg;
    logic [LW-1:0]       w2_pv_wd_next;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LW-1:0]       result_node_reg;
    logic                found_reg;
    logic [2:0]          status_reg;
    logic [LW-1:0]       count_reg;
    logic                out_load;

    logic [LW-1:0] node_ext;
    logic [LW-1:0] anchor_ext;
    logic [LW-1:0] tgt;
    logic          tgt_member;
    logic          first_like;
    logic          last_like;

    assign node_ext   = {1'b0, node_reg};
    assign anchor_ext = {1'b0, anchor_reg};

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_load      = cmd.finish && stat.out_free;

    // read addresses come straight from the item being accepted, or from the head or tail for the end removes
    always_comb
    begin
        case (dllm_pkg::op_t'(op))
            dllm_pkg::OP_INS_AFTER:
            begin
                rd_next_addr = anchor;
                rd_prev_addr = node;
            end
            dllm_pkg::OP_INS_BEFORE:
            begin
                rd_next_addr = node;
                rd_prev_addr = anchor;
            end
            dllm_pkg::OP_REM_FIRST:
            begin
                rd_next_addr = head_reg[NW-1:0];
                rd_prev_addr = head_reg[NW-1:0];
            end
            dllm_pkg::OP_REM_LAST:
            begin
                rd_next_addr = tail_reg[NW-1:0];
                rd_prev_addr = tail_reg[NW-1:0];
            end
            default:
            begin
                rd_next_addr = node;
                rd_prev_addr = node;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (cmd.capture)
        begin
            rd_next_reg <= next_mem[rd_next_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.capture)
        begin
            rd_prev_reg <= prev_mem[rd_prev_addr];
        end
    end

    // node removed by the three remove operations
    always_comb
    begin
        case (op_reg)
            dllm_pkg::OP_REM_FIRST: tgt = head_reg;
            dllm_pkg::OP_REM_LAST:  tgt = tail_reg;
            default:                tgt = node_ext;
        endcase
    end

    assign tgt_member = (tgt != dllm_pkg::NULL_LINK) && member_reg[tgt[NW-1:0]];
    assign first_like = (op_reg == dllm_pkg::OP_INS_FIRST)
                     || ((op_reg == dllm_pkg::OP_INS_BEFORE) && (anchor_ext == head_reg));
    assign last_like  = (op_reg == dllm_pkg::OP_INS_LAST)
                     || ((op_reg == dllm_pkg::OP_INS_AFTER) && (anchor_ext == tail_reg));

    always_comb
    begin
        nx_we         = 1'b0;
        nx_wa         = '0;
        nx_wd         = '0;
        pv_we         = 1'b0;
        pv_wa         = '0;
        pv_wd         = '0;
        member_next   = member_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        size_next     = size_reg;
        res_next      = res_reg;
        fnd_next      = fnd_reg;
        st_next       = st_reg;
        w2_nx_we_next = w2_nx_we_reg;
        w2_nx_wa_next = w2_nx_wa_reg;
        w2_nx_wd_next = w2_nx_wd_reg;
        w2_pv_we_next = w2_pv_we_reg;
        w2_pv_wa_next = w2_pv_wa_reg;
        w2_pv_wd_next = w2_pv_wd_reg;

        if (cmd.exec_step)
        begin
            res_next      = dllm_pkg::NULL_LINK;
            fnd_next      = 1'b0;
            st_next       = dllm_pkg::ST_OK;
            w2_nx_we_next = 1'b0;
            w2_pv_we_next = 1'b0;
            case (op_reg)
                dllm_pkg::OP_INS_FIRST, dllm_pkg::OP_INS_LAST,
                dllm_pkg::OP_INS_AFTER, dllm_pkg::OP_INS_BEFORE:
                begin
                    if (member_reg[node_reg])
                    begin
                        st_next = dllm_pkg::ST_LISTED;
                    end
                    else if ((op_reg inside {dllm_pkg::OP_INS_AFTER, dllm_pkg::OP_INS_BEFORE})
                             && !member_reg[anchor_reg])
                    begin
                        st_next = dllm_pkg::ST_NO_ANCHOR;
                    end
                    else
                    begin
                        member_next[node_reg] = 1'b1;
                        size_next             = size_reg + LW'(1);
                        res_next              = node_ext;
                        nx_we                 = 1'b1;
                        nx_wa                 = node_reg;
                        pv_we                 = 1'b1;
                        pv_wa                 = node_reg;
                        if (first_like)
                        begin
                            nx_wd         = head_reg;
                            pv_wd         = dllm_pkg::NULL_LINK;
                            w2_pv_we_next = (head_reg != dllm_pkg::NULL_LINK);
                            w2_pv_wa_next = head_reg[NW-1:0];
                            w2_pv_wd_next = node_ext;
                            head_next     = node_ext;
                            if (head_reg == dllm_pkg::NULL_LINK)
                            begin
                                tail_next = node_ext;
                            end
                        end
                        else if (last_like)
                        begin
                            nx_wd         = dllm_pkg::NULL_LINK;
                            pv_wd         = tail_reg;
                            w2_nx_we_next = (tail_reg != dllm_pkg::NULL_LINK);
                            w2_nx_wa_next = tail_reg[NW-1:0];
                            w2_nx_wd_next = node_ext;
                            tail_next     = node_ext;
                            if (tail_reg == dllm_pkg::NULL_LINK)
                            begin
                                head_next = node_ext;
                            end
                        end
                        else if (op_reg == dllm_pkg::OP_INS_AFTER)
                        begin
                            // anchor has a successor here
                            nx_wd         = rd_next_reg;
                            pv_wd         = anchor_ext;
                            w2_pv_we_next = 1'b1;
                            w2_pv_wa_next = rd_next_reg[NW-1:0];
                            w2_pv_wd_next = node_ext;
                            w2_nx_we_next = 1'b1;
                            w2_nx_wa_next = anchor_reg;
                            w2_nx_wd_next = node_ext;
                        end
                        else
                        begin
                            // anchor has a predecessor here
                            pv_wd         = rd_prev_reg;
                            nx_wd         = anchor_ext;
                            w2_nx_we_next = 1'b1;
                            w2_nx_wa_next = rd_prev_reg[NW-1:0];
                            w2_nx_wd_next = node_ext;
                            w2_pv_we_next = 1'b1;
                            w2_pv_wa_next = anchor_reg;
                            w2_pv_wd_next = node_ext;
                        end
                    end
                end
                dllm_pkg::OP_REM_FIRST, dllm_pkg::OP_REM_LAST, dllm_pkg::OP_REMOVE:
                begin
                    if (!tgt_member)
                    begin
                        st_next = (op_reg == dllm_pkg::OP_REMOVE) ? dllm_pkg::ST_UNLISTED
                                                                   : dllm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        member_next[tgt[NW-1:0]] = 1'b0;
                        if (size_reg != '0)
                        begin
                            size_next = size_reg - LW'(1);
                        end
                        res_next = tgt;
                        if (rd_prev_reg != dllm_pkg::NULL_LINK)
                        begin
                            nx_we = 1'b1;
                            nx_wa = rd_prev_reg[NW-1:0];
                            nx_wd = rd_next_reg;
                        end
                        else
                        begin
                            head_next = rd_next_reg;
                        end
                        if (rd_next_reg != dllm_pkg::NULL_LINK)
                        begin
                            pv_we = 1'b1;
                            pv_wa = rd_next_reg[NW-1:0];
                            pv_wd = rd_prev_reg;
                        end
                        else
                        begin
                            tail_next = rd_prev_reg;
                        end
                    end
                end
                dllm_pkg::OP_SEARCH:
                begin
                    if (member_reg[node_reg])
                    begin
                        fnd_next = 1'b1;
                        res_next = node_ext;
                    end
                end
                default:
                begin
                    st_next = dllm_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.finish)
        begin
            nx_we = w2_nx_we_reg;
            nx_wa = w2_nx_wa_reg;
            nx_wd = w2_nx_wd_reg;
            pv_we = w2_pv_we_reg;
            pv_wa = w2_pv_wa_reg;
            pv_wd = w2_pv_wd_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg    <= '0;
            head_reg      <= dllm_pkg::NULL_LINK;
            tail_reg      <= dllm_pkg::NULL_LINK;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            w2_nx_we_reg  <= 1'b0;
            w2_pv_we_reg  <= 1'b0;
        end
        else
        begin
            member_reg    <= member_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            w2_nx_we_reg  <= w2_nx_we_next;
            w2_pv_we_reg  <= w2_pv_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= dllm_pkg::op_t'(op);
            node_reg   <= node;
            anchor_reg <= anchor;
        end
        res_reg      <= res_next;
        fnd_reg      <= fnd_next;
        st_reg       <= st_next;
        w2_nx_wa_reg <= w2_nx_wa_next;
        w2_nx_wd_reg <= w2_nx_wd_next;
        w2_pv_wa_reg <= w2_pv_wa_next;
        w2_pv_wd_reg <= w2_pv_wd_next;
        if (out_load)
        begin
            result_node_reg <= res_reg;
            found_reg       <= fnd_reg;
            status_reg      <= st_reg;
            count_reg       <= size_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_node = result_node_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign count       = count_reg;

endmodule

// File: hw/rtl/doubly_linked_list_manager_core.sv
// One doubly linked list over a pool of 64 node indices, with index 64 as null. With the
// result register free, the accept cycle reads both link tables, the next cycle checks
// membership and does the first link writes and the head, tail and size updates, and the
// last does the remaining link writes and loads the result register; the writes are split
// because each link table has a single write port. A new item is accepted while the
// previous result still waits to be taken; a finished item that finds the result register
// still full holds in its last cycle until it drains. Membership bits clear at reset. The
// link tables are not cleared: only listed nodes' entries are used, so no clearing pass runs.
module doubly_linked_list_manager_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  op,
    input  logic [dllm_pkg::NODE_W-1:0] node,
    input  logic [dllm_pkg::NODE_W-1:0] anchor,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dllm_pkg::LINK_W-1:0] result_node,
    output logic                        found,
    output logic [2:0]                  status,
    output logic [dllm_pkg::LINK_W-1:0] count
);

    dllm_pkg::cmd_t  cmd;
    dllm_pkg::stat_t stat;

    dllm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dllm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .node        (node),
        .anchor      (anchor),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_node (result_node),
        .found       (found),
        .status      (status),
        .count       (count)
    );

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in flight");

    // failed operations name no node
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != 3'(dllm_pkg::ST_OK))) |->
            ((result_node == dllm_pkg::NULL_LINK) && !found))
        else $error("error result carries a node");

    // a found search names a real node
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (result_node != dllm_pkg::NULL_LINK))
        else $error("found without a node");

    // list size never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= dllm_pkg::LINK_W'(dllm_pkg::NODES)))
        else $error("count beyond pool size");

endmodule

// File: dv/tb_doubly_linked_list_manager_core.sv
module tb_doubly_linked_list_manager_core;
    import dllm_pkg::*;

    localparam int GEN = 0;          // list image kept by the stimulus side
    localparam int CHK = 1;          // list image kept by the result checker
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        op_t               code;
        logic [NODE_W-1:0] idx;
        logic [NODE_W-1:0] anc;
    } list_cmd_t;

    typedef struct packed {
        logic [LINK_W-1:0] res;
        logic              fnd;
        status_t           st;
        logic [LINK_W-1:0] cnt;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        op = OP_SEARCH;
    logic [NODE_W-1:0] node = '0;
    logic [NODE_W-1:0] anchor = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [LINK_W-1:0] result_node;
    logic              found;
    logic [2:0]        status;
    logic [LINK_W-1:0] count;

    doubly_linked_list_manager_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .node        (node),
        .anchor      (anchor),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_node (result_node),
        .found       (found),
        .status      (status),
        .count       (count)
    );

    // two copies of the list: links, membership, ends and size
    logic [LINK_W-1:0] next_tab [2][NODES];
    logic [LINK_W-1:0] prev_tab [2][NODES];
    bit                member_tab [2][NODES];
    logic [LINK_W-1:0] head_r [2];
    logic [LINK_W-1:0] tail_r [2];
    logic [LINK_W-1:0] size_r [2];

    list_cmd_t    pending_ops[$];
    list_result_t expected_results[$];
    list_cmd_t    cur_cmd;
    int           ops_queued = 0;
    int           ops_accepted = 0;
    int           mismatch_cnt = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           fill_goal = 64;
    bit           in_fire = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic void unlink_entry(input int w, input logic [LINK_W-1:0] n);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] q;
        p = prev_tab[w][n[NODE_W-1:0]];
        q = next_tab[w][n[NODE_W-1:0]];
        if (p != NULL_LINK) next_tab[w][p[NODE_W-1:0]] = q;
        else head_r[w] = q;
        if (q != NULL_LINK) prev_tab[w][q[NODE_W-1:0]] = p;
        else tail_r[w] = p;
        member_tab[w][n[NODE_W-1:0]] = 1'b0;
        if (size_r[w] != 0) size_r[w] = size_r[w] - 1'b1;
    endfunction

    function automatic list_result_t apply_list_op(input int w, input op_t o,
                                                   input logic [NODE_W-1:0] n,
                                                   input logic [NODE_W-1:0] a);
        list_result_t r;
        logic [LINK_W-1:0] nl;
        logic [LINK_W-1:0] al;
        logic [LINK_W-1:0] t;
        logic [LINK_W-1:0] nb;
        nl = {1'b0, n};
        al = {1'b0, a};
        r.res = NULL_LINK;
        r.fnd = 1'b0;
        r.st = ST_OK;
        case (o)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (member_tab[w][n])
                    r.st = ST_LISTED;
                else if ((o == OP_INS_AFTER || o == OP_INS_BEFORE) && !member_tab[w][a])
                    r.st = ST_NO_ANCHOR;
                else
                begin
                    if (o == OP_INS_FIRST || (o == OP_INS_BEFORE && al == head_r[w]))
                    begin
                        prev_tab[w][n] = NULL_LINK;
                        next_tab[w][n] = head_r[w];
                        if (head_r[w] != NULL_LINK) prev_tab[w][head_r[w][NODE_W-1:0]] = nl;
                        else tail_r[w] = nl;
                        head_r[w] = nl;
                    end
                    else if (o == OP_INS_LAST || (o == OP_INS_AFTER && al == tail_r[w]))
                    begin
                        next_tab[w][n] = NULL_LINK;
                        prev_tab[w][n] = tail_r[w];
                        if (tail_r[w] != NULL_LINK) next_tab[w][tail_r[w][NODE_W-1:0]] = nl;
                        else head_r[w] = nl;
                        tail_r[w] = nl;
                    end
                    else if (o == OP_INS_AFTER)
                    begin
                        // anchor is not the tail, so its successor is a real node
                        nb = next_tab[w][a];
                        next_tab[w][n] = nb;
                        prev_tab[w][n] = al;
                        prev_tab[w][nb[NODE_W-1:0]] = nl;
                        next_tab[w][a] = nl;
                    end
                    else
                    begin
                        nb = prev_tab[w][a];
                        prev_tab[w][n] = nb;
                        next_tab[w][n] = al;
                        next_tab[w][nb[NODE_W-1:0]] = nl;
                        prev_tab[w][a] = nl;
                    end
                    member_tab[w][n] = 1'b1;
                    size_r[w] = size_r[w] + 1'b1;
                    r.res = nl;
                end
            end
            OP_REM_FIRST, OP_REM_LAST:
            begin
                t = (o == OP_REM_FIRST) ? head_r[w] : tail_r[w];
                if (t == NULL_LINK || !member_tab[w][t[NODE_W-1:0]])
                    r.st = ST_EMPTY;
                else
                begin
                    unlink_entry(w, t);
                    r.res = t;
                end
            end
            OP_REMOVE:
            begin
                if (!member_tab[w][n])
                    r.st = ST_UNLISTED;
                else
                begin
                    unlink_entry(w, nl);
                    r.res = nl;
                end
            end
            default:
            begin
                if (member_tab[w][n])
                begin
                    r.fnd = 1'b1;
                    r.res = nl;
                end
            end
        endcase
        r.cnt = size_r[w];
        return r;
    endfunction

    task automatic queue_op(input op_t o, input int n, input int a);
        list_cmd_t c;
        list_result_t dummy;
        c.code = o;
        c.idx = n[NODE_W-1:0];
        c.anc = a[NODE_W-1:0];
        dummy = apply_list_op(GEN, c.code, c.idx, c.anc);
        pending_ops.push_back(c);
        ops_queued++;
    endtask

    // random node whose membership matches, scanning from a random start
    function automatic int pick_node(input bit want_listed);
        int base;
        int k;
        base = $urandom_range(0, NODES - 1);
        for (k = 0; k < NODES; k++)
            if (member_tab[GEN][(base + k) % NODES] == want_listed)
                return (base + k) % NODES;
        return base;
    endfunction

    task automatic queue_random_op();
        int roll;
        op_t o;
        bit grow;
        roll = $urandom_range(0, 99);
        grow = size_r[GEN] < fill_goal;
        if (roll < 8)
        begin
            // noise: anything at all
            queue_op(op_t'($urandom_range(0, 7)), $urandom_range(0, NODES - 1),
                     $urandom_range(0, NODES - 1));
        end
        else if ($urandom_range(0, 99) < (grow ? 70 : 25))
        begin
            o = op_t'($urandom_range(0, 3));
            queue_op(o, pick_node($urandom_range(0, 9) == 0),
                     pick_node($urandom_range(0, 9) != 0));
        end
        else
        begin
            o = op_t'($urandom_range(4, 7));
            if (o == OP_SEARCH)
                queue_op(o, pick_node($urandom_range(0, 1)), $urandom_range(0, NODES - 1));
            else
                queue_op(o, pick_node($urandom_range(0, 9) != 0),
                         $urandom_range(0, NODES - 1));
        end
    endtask

    // driver: inputs move on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_cmd = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    op <= cur_cmd.code;
                    node <= cur_cmd.idx;
                    anchor <= cur_cmd.anc;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: results are checked before the item taken on the same edge is predicted
    always @(posedge clk)
    begin : monitor
        list_result_t e;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result node %0d with no item outstanding",
                                          result_node));
            else
            begin
                e = expected_results.pop_front();
                if (result_node !== e.res)
                    report_mismatch($sformatf("result_node %0d, expected %0d",
                                              result_node, e.res));
                if (found !== e.fnd)
                    report_mismatch($sformatf("found %0b, expected %0b", found, e.fnd));
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
                if (count !== e.cnt)
                    report_mismatch($sformatf("count %0d, expected %0d", count, e.cnt));
            end
        end
        if (in_fire)
        begin
            expected_results.push_back(apply_list_op(CHK, op_t'(op), node, anchor));
            ops_accepted++;
        end
    end

    initial
    begin
        int w;
        int k;
        int ph;
        int per_phase;
        for (w = 0; w < 2; w++)
        begin
            for (k = 0; k < NODES; k++)
            begin
                next_tab[w][k] = NULL_LINK;
                prev_tab[w][k] = NULL_LINK;
                member_tab[w][k] = 1'b0;
            end
            head_r[w] = NULL_LINK;
            tail_r[w] = NULL_LINK;
            size_r[w] = '0;
        end

        // directed: empty list errors, check order, ends and middle of the list
        queue_op(OP_SEARCH, 0, 63);
        queue_op(OP_REM_FIRST, 0, 0);
        queue_op(OP_REM_LAST, 63, 63);
        queue_op(OP_REMOVE, 5, 0);
        queue_op(OP_INS_AFTER, 1, 2);
        queue_op(OP_INS_BEFORE, 7, 7);
        queue_op(OP_INS_FIRST, 0, 0);
        queue_op(OP_INS_LAST, 63, 0);
        queue_op(OP_INS_FIRST, 0, 63);
        queue_op(OP_INS_AFTER, 63, 63);
        queue_op(OP_INS_AFTER, 5, 63);
        queue_op(OP_INS_BEFORE, 10, 0);
        queue_op(OP_INS_AFTER, 20, 0);
        queue_op(OP_INS_BEFORE, 30, 63);
        queue_op(OP_INS_BEFORE, 40, 41);
        queue_op(OP_SEARCH, 63, 0);
        queue_op(OP_SEARCH, 62, 63);
        queue_op(OP_REMOVE, 20, 0);
        queue_op(OP_REMOVE, 20, 0);
        queue_op(OP_REM_FIRST, 0, 0);
        queue_op(OP_REM_LAST, 0, 0);
        queue_op(OP_REMOVE, 0, 0);
        queue_op(OP_INS_LAST, 42, 21);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        per_phase = 335;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (k = 0; k < per_phase; k++)
            begin
                // swing the list between full, empty and somewhere between
                if (k % 170 == 0)
                    fill_goal = (ph % 2 == 0) ? ((k == 0) ? NODES : 0) : $urandom_range(0, NODES);
                queue_random_op();
            end
            while (pending_ops.size() != 0) @(posedge clk);
        end

        while (ops_accepted != ops_queued || expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
